/* hw/rtl/ppdh_pkg.sv */
// shared types and constants for the periodic pair distance histogram
`timescale 1ns / 1ps
`default_nettype none

package ppdh_pkg;

  // default sizes
  localparam int DEF_NUM_BINS   = 200;
  localparam int DEF_COORD_BITS = 18;
  localparam int DEF_COUNT_BITS = 16;

  // configuration register widths and reset values
  localparam int CELL_W     = 18;
  localparam int BINW_W     = 10;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int READ_BIN_W = 8;

  localparam logic [CELL_W-1:0] RESET_CELL      = 18'd20000;
  localparam logic [BINW_W-1:0] RESET_BIN_WIDTH = 10'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_X    = 2'd0,
    REG_CELL_Y    = 2'd1,
    REG_BIN_WIDTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    KIND_SAME_FIRST  = 2'd0,
    KIND_MIXED       = 2'd1,
    KIND_SAME_SECOND = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ABS,
    ST_WRAP,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_DIV,
    ST_CHECK,
    ST_READ,
    ST_WRITE,
    ST_RREAD,
    ST_ROUT
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/periodic_pair_distance_histogram.sv */
// Pair distance histogram with one shared subtract/compare unit. After reset a clearing
// pass zeroes the NUM_BINS+1 bins, one per cycle, and no request is taken during it.
// A read request is accepted, reads the memory and loads the output register once that
// register is free. A pair request with both atoms in the bulk runs abs, wrap, multiply
// and accumulate per axis through the single multiplier, then M+1 square root steps and
// M+1 divide steps through the same subtract/compare unit, M = max(COORD_BITS, 18),
// then a read-modify-write of the bin memory, skipped if the bin is past the last one.
// A pair with a non-bulk atom is dropped at acceptance. A new request is taken while a
// read result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module periodic_pair_distance_histogram import ppdh_pkg::*; #(
  parameter int NUM_BINS   = DEF_NUM_BINS,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [CFG_IDX_W-1:0]                       cfg_index,
  input  logic [CFG_DATA_W-1:0]                      cfg_data,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // first_x, first_y, first_z, first_species, first_is_bulk,
  // second_x, second_y, second_z, second_species, second_is_bulk, read_bin, zero fill
  input  logic [((6*COORD_BITS+12+7)/8)*8-1:0]       s_tdata,
  // func
  input  logic                                       s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // bin_number, count_same_first, count_mixed, count_same_second, zero fill
  output logic [((8+3*COUNT_BITS+7)/8)*8-1:0]        m_tdata
);

  localparam int CB      = COORD_BITS;
  localparam int CNT     = COUNT_BITS;
  localparam int OUT_W   = ((8 + 3*CNT + 7) / 8) * 8;
  localparam int MW      = (CB > CELL_W) ? CB : CELL_W;
  localparam int N       = MW + 1;
  localparam int SUM_W   = 2 * N;
  localparam int UW      = N + 3;
  localparam int STEP_W  = $clog2(N);
  localparam int DEPTH   = NUM_BINS + 1;
  localparam int BIN_W   = $clog2(DEPTH);
  localparam int ENTRY_W = 3 * CNT;

  // input field offsets
  localparam int FX_LO = 0;
  localparam int FY_LO = CB;
  localparam int FZ_LO = 2*CB;
  localparam int FS_B  = 3*CB;
  localparam int FB_B  = 3*CB + 1;
  localparam int SX_LO = 3*CB + 2;
  localparam int SY_LO = 4*CB + 2;
  localparam int SZ_LO = 5*CB + 2;
  localparam int SS_B  = 6*CB + 2;
  localparam int SB_B  = 6*CB + 3;
  localparam int RB_LO = 6*CB + 4;

  state_t state, state_next;

  logic [CELL_W-1:0] cell_x, cell_y;
  logic [BINW_W-1:0] bin_width;

  logic signed [CB-1:0] fx, fy, fz, sx, sy, sz;
  kind_t                kind;
  axis_t                ax;
  logic [READ_BIN_W-1:0] rd_bin;
  logic                  rd_in_range;

  logic [CB-1:0]      dabs;
  logic [MW-1:0]      mag;
  logic [2*MW-1:0]    prod;
  logic [SUM_W-1:0]   sum;
  logic [UW-1:0]      rem;
  logic [N-1:0]       root;
  logic [STEP_W-1:0]  step;
  logic [BIN_W-1:0]   addr;

  logic                  out_valid;
  logic [READ_BIN_W-1:0] out_bin;
  logic [ENTRY_W-1:0]    out_cnt;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] inc_data;
  logic [ENTRY_W-1:0] mem_wdata;

  logic mem_rd, mem_we, load_out;
  logic step_last, q_in_range, in_bulk, in_rd_range;

  // shared subtract/compare unit
  logic [UW-1:0] ua, ub, u_diff;
  logic          u_ge;

  // per-axis datapath
  logic signed [CB-1:0] a_sel, b_sel;
  logic signed [CB:0]   d1;
  logic [CB:0]          d1n;
  logic [CB-1:0]        dabs_next;
  logic [CELL_W-1:0]    cell_sel;
  logic                 do_wrap;
  logic [MW-1:0]        dabs_e, cell_e, mag_next;
  logic [BINW_W-1:0]    w_eff;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_x    <= RESET_CELL;
      cell_y    <= RESET_CELL;
      bin_width <= RESET_BIN_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_X:    cell_x    <= cfg_data[CELL_W-1:0];
        REG_CELL_Y:    cell_y    <= cfg_data[CELL_W-1:0];
        REG_BIN_WIDTH: bin_width <= cfg_data[BINW_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (bin_width == '0) ? BINW_W'(1) : bin_width;

  // ---------------------------------------------------------------- axis logic
  always_comb begin
    case (ax)
      AX_X: begin
        a_sel = fx; b_sel = sx; cell_sel = cell_x; do_wrap = 1'b1;
      end
      AX_Y: begin
        a_sel = fy; b_sel = sy; cell_sel = cell_y; do_wrap = 1'b1;
      end
      default: begin
        a_sel = fz; b_sel = sz; cell_sel = '0; do_wrap = 1'b0;
      end
    endcase
  end

  assign d1        = $signed({a_sel[CB-1], a_sel}) - $signed({b_sel[CB-1], b_sel});
  assign d1n       = -d1;
  assign dabs_next = d1[CB] ? d1n[CB-1:0] : d1[CB-1:0];

  assign dabs_e = MW'(dabs);
  assign cell_e = MW'(cell_sel);

  // minimum image: subtract the cell once when twice the distance exceeds it
  always_comb begin
    mag_next = dabs_e;
    if (do_wrap && ((MW+1)'({dabs, 1'b0}) > (MW+1)'(cell_sel))) begin
      mag_next = (dabs_e < cell_e) ? (cell_e - dabs_e) : (dabs_e - cell_e);
    end
  end

  // ---------------------------------------------------------------- shared unit
  always_comb begin
    if (state == ST_SQRT) begin
      ua = {rem[UW-3:0], sum[SUM_W-1 -: 2]};
      ub = UW'({root, 2'b01});
    end else begin
      ua = {rem[UW-2:0], root[N-1]};
      ub = UW'(w_eff);
    end
  end

  assign u_diff = ua - ub;
  assign u_ge   = (ua >= ub);

  assign step_last   = (step == STEP_W'(N - 1));
  assign q_in_range  = (root <= N'(NUM_BINS));
  assign in_bulk     = s_tdata[FB_B] & s_tdata[SB_B];
  assign in_rd_range = (32'(s_tdata[RB_LO +: READ_BIN_W]) <= 32'(NUM_BINS));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_rd     = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr == BIN_W'(NUM_BINS)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser) begin
            state_next = ST_RREAD;
          end else if (in_bulk) begin
            state_next = ST_ABS;
          end
        end
      end
      ST_ABS:  state_next = ST_WRAP;
      ST_WRAP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = (ax == AX_Z) ? ST_SQRT : ST_ABS;
      ST_SQRT: if (step_last) state_next = ST_DIV;
      ST_DIV:  if (step_last) state_next = ST_CHECK;
      ST_CHECK: state_next = q_in_range ? ST_READ : ST_IDLE;
      ST_READ: begin
        mem_rd     = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RREAD: begin
        mem_rd     = rd_in_range;
        state_next = ST_ROUT;
      end
      ST_ROUT: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: addr <= addr + BIN_W'(1);
        ST_IDLE: begin
          if (s_tvalid && s_tuser) addr <= BIN_W'(s_tdata[RB_LO +: READ_BIN_W]);
        end
        ST_CHECK: addr <= BIN_W'(root);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        fx          <= s_tdata[FX_LO +: CB];
        fy          <= s_tdata[FY_LO +: CB];
        fz          <= s_tdata[FZ_LO +: CB];
        sx          <= s_tdata[SX_LO +: CB];
        sy          <= s_tdata[SY_LO +: CB];
        sz          <= s_tdata[SZ_LO +: CB];
        kind        <= kind_t'({1'b0, s_tdata[FS_B]} + {1'b0, s_tdata[SS_B]});
        rd_bin      <= s_tdata[RB_LO +: READ_BIN_W];
        rd_in_range <= in_rd_range;
        ax          <= AX_X;
        sum         <= '0;
      end
      ST_ABS:  dabs <= dabs_next;
      ST_WRAP: mag  <= mag_next;
      ST_MUL:  prod <= (2*MW)'(mag) * (2*MW)'(mag);
      ST_ACC: begin
        sum  <= sum + SUM_W'(prod);
        rem  <= '0;
        root <= '0;
        step <= '0;
        case (ax)
          AX_X:    ax <= AX_Y;
          default: ax <= AX_Z;
        endcase
      end
      ST_SQRT: begin
        // one result bit per step, two radicand bits consumed
        sum  <= {sum[SUM_W-3:0], 2'b00};
        rem  <= step_last ? '0 : (u_ge ? u_diff : ua);
        root <= {root[N-2:0], u_ge};
        step <= step_last ? '0 : step + STEP_W'(1);
      end
      ST_DIV: begin
        // restoring divide, quotient shifts into root
        rem  <= u_ge ? u_diff : ua;
        root <= {root[N-2:0], u_ge};
        step <= step + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- bin memory
  always_comb begin
    logic [CNT-1:0] c;
    inc_data = rdata;
    case (kind)
      KIND_SAME_FIRST: c = rdata[0 +: CNT];
      KIND_MIXED:      c = rdata[CNT +: CNT];
      default:         c = rdata[2*CNT +: CNT];
    endcase
    if (c != '1) c = c + CNT'(1);
    case (kind)
      KIND_SAME_FIRST: inc_data[0 +: CNT]     = c;
      KIND_MIXED:      inc_data[CNT +: CNT]   = c;
      default:         inc_data[2*CNT +: CNT] = c;
    endcase
  end

  assign mem_wdata = (state == ST_CLEAR) ? '0 : inc_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_rd) rdata <= mem[addr];
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bin <= rd_bin;
      out_cnt <= rd_in_range ? rdata : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_cnt, out_bin});

  // ---------------------------------------------------------------- assertions
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(addr) <= 32'(NUM_BINS)))
    else $error("bin memory write beyond the last bin");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT || state == ST_DIV) |-> (32'(step) < 32'(N)))
    else $error("step counter ran past the last step");

  a_clear_first: assert property (@(posedge clk)
    $fell(rst) |-> (state == ST_CLEAR && addr == '0))
    else $error("clearing pass did not start after reset");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || m_tready))
    else $error("output register overwritten while full");

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for the periodic pair distance histogram
`timescale 1ns / 1ps

module tb;
  import ppdh_pkg::*;

  localparam int CW          = DEF_COORD_BITS;
  localparam int LAST_BIN    = DEF_NUM_BINS;
  localparam int REQ_W       = ((6*DEF_COORD_BITS+12+7)/8)*8;
  localparam int RPT_W       = ((8+3*DEF_COUNT_BITS+7)/8)*8;
  localparam int SETTLE      = 120;
  localparam int LIMIT       = 2000000;
  localparam int MAXC        = 131071;
  localparam int MINC        = -131072;
  localparam logic FUNC_PAIR = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [DEF_COUNT_BITS-1:0] COUNT_FULL = '1;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 species;
    logic                 bulk;
  } atom_t;

  typedef struct {
    logic        func;
    atom_t       first, second;
    logic [7:0]  read_bin;
  } hist_req_t;

  typedef struct {
    logic [7:0]                bin_number;
    logic [DEF_COUNT_BITS-1:0] same_first, mixed, same_second;
  } bin_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // first_x, first_y, first_z, first_species, first_is_bulk,
  // second_x, second_y, second_z, second_species, second_is_bulk, read_bin
  logic [REQ_W-1:0]     s_tdata = '0;
  // func
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // bin_number, count_same_first, count_mixed, count_same_second, zero fill
  logic [RPT_W-1:0]     m_tdata;

  periodic_pair_distance_histogram dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // mirror of the block's registers and histogram
  logic [CELL_W-1:0]         cell_x_now = RESET_CELL;
  logic [CELL_W-1:0]         cell_y_now = RESET_CELL;
  logic [BINW_W-1:0]         bin_w_now  = RESET_BIN_WIDTH;
  logic [DEF_COUNT_BITS-1:0] bin_tally [0:LAST_BIN][0:2];
  bin_report_t               reports_due [$];
  bin_report_t               want_report;

  bit steady = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int requests_sent = 0;
  int reports_checked = 0;
  int settings_used = 1;
  int cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 20) hold_left <= pick_gap();
    end
  end

  function automatic longint axis_gap(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                      bit wrap, longint cell_len);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    if (wrap && d * 2 > cell_len) d = d - cell_len;
    if (d < 0) d = -d;
    return d;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  // histogram update for a pair, bin report for a read
  task automatic tally_request(hist_req_t r);
    bin_report_t rep;
    longint dx, dy, dz;
    longint unsigned radius, w, bin;
    kind_t k;
    if (r.func == FUNC_READ) begin
      rep.bin_number = r.read_bin;
      rep.same_first = '0;
      rep.mixed = '0;
      rep.same_second = '0;
      if (r.read_bin <= LAST_BIN) begin
        rep.same_first  = bin_tally[r.read_bin][KIND_SAME_FIRST];
        rep.mixed       = bin_tally[r.read_bin][KIND_MIXED];
        rep.same_second = bin_tally[r.read_bin][KIND_SAME_SECOND];
      end
      reports_due.push_back(rep);
    end else if (r.first.bulk && r.second.bulk) begin
      dx = axis_gap(r.first.x, r.second.x, 1'b1, longint'(cell_x_now));
      dy = axis_gap(r.first.y, r.second.y, 1'b1, longint'(cell_y_now));
      dz = axis_gap(r.first.z, r.second.z, 1'b0, 64'sd0);
      radius = root_floor(dx * dx + dy * dy + dz * dz);
      w = (bin_w_now == 0) ? 64'd1 : 64'(bin_w_now);
      bin = radius / w;
      if (bin <= LAST_BIN) begin
        if (r.first.species && r.second.species) k = KIND_SAME_SECOND;
        else if (r.first.species || r.second.species) k = KIND_MIXED;
        else k = KIND_SAME_FIRST;
        if (bin_tally[bin][k] != COUNT_FULL) bin_tally[bin][k] = bin_tally[bin][k] + 1'b1;
      end
    end
  endtask

  task automatic check_field(string name, logic [DEF_COUNT_BITS-1:0] want,
                             logic [DEF_COUNT_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (reports_due.size() == 0) begin
        errors++;
        $error("bin report for bin %0d with no read pending", m_tdata[7:0]);
      end else begin
        want_report = reports_due.pop_front();
        reports_checked++;
        check_field("bin_number", 16'(want_report.bin_number), 16'(m_tdata[7:0]));
        check_field("count_same_first", want_report.same_first, m_tdata[23:8]);
        check_field("count_mixed", want_report.mixed, m_tdata[39:24]);
        check_field("count_same_second", want_report.same_second, m_tdata[55:40]);
      end
    end
  end

  function automatic atom_t place(int x, int y, int z, logic species, logic bulk);
    atom_t a;
    a.x = CW'(x);
    a.y = CW'(y);
    a.z = CW'(z);
    a.species = species;
    a.bulk = bulk;
    return a;
  endfunction

  function automatic atom_t any_atom();
    return place($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
  endfunction

  function automatic hist_req_t pair_of(atom_t a, atom_t b);
    hist_req_t r;
    r.func = FUNC_PAIR;
    r.first = a;
    r.second = b;
    r.read_bin = 8'($urandom);
    return r;
  endfunction

  // read request; the atom fields carry junk that the block must ignore
  function automatic hist_req_t bin_query(int bin);
    hist_req_t r;
    r = pair_of(any_atom(), any_atom());
    r.func = FUNC_READ;
    r.read_bin = 8'(bin);
    return r;
  endfunction

  function automatic int spread(int h);
    return int'($urandom_range(0, 2 * h)) - h;
  endfunction

  task automatic send_request(hist_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.func;
    s_tdata  <= {r.read_bin, r.second.bulk, r.second.species, r.second.z, r.second.y,
                 r.second.x, r.first.bulk, r.first.species, r.first.z, r.first.y, r.first.x};
    do @(posedge clk); while (s_tready !== 1'b1);
    requests_sent++;
    tally_request(r);
  endtask

  // drain everything, including a pair that leaves no report behind
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CELL_X:    cell_x_now = data[CELL_W-1:0];
      REG_CELL_Y:    cell_y_now = data[CELL_W-1:0];
      REG_BIN_WIDTH: bin_w_now  = data[BINW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_directed_pairs();
    send_request(pair_of(place(0, 0, 0, 0, 1), place(0, 0, 0, 0, 1)));
    send_request(pair_of(place(0, 0, 0, 0, 1), place(300, 400, 0, 1, 1)));
    send_request(pair_of(place(300, 400, 0, 1, 1), place(0, 0, 0, 0, 1)));
    // exactly on the last bin, then one bin past it
    send_request(pair_of(place(0, 0, -5000, 1, 1), place(0, 0, 5000, 1, 1)));
    send_request(pair_of(place(0, 0, 0, 1, 1), place(0, 0, 10050, 1, 1)));
    // minimum image in x and y, and the half-cell boundary that does not wrap
    send_request(pair_of(place(9900, 0, 0, 0, 1), place(-9900, 0, 0, 0, 1)));
    send_request(pair_of(place(0, -9990, 0, 1, 1), place(0, 9990, 0, 0, 1)));
    send_request(pair_of(place(10000, 0, 0, 0, 1), place(0, 0, 0, 0, 1)));
    // z is never wrapped
    send_request(pair_of(place(0, 0, 9900, 0, 1), place(0, 0, -99, 0, 1)));
    send_request(pair_of(place(0, 0, 19800, 0, 1), place(0, 0, 0, 0, 1)));
    send_request(pair_of(place(0, 0, 0, 0, 0), place(0, 0, 0, 0, 1)));
    send_request(pair_of(place(0, 0, 0, 0, 1), place(0, 0, 0, 0, 0)));
    send_request(pair_of(place(MAXC, MAXC, MAXC, 1, 1), place(MINC, MINC, MINC, 1, 1)));
    send_request(pair_of(place(MINC, MAXC, MINC, 0, 1), place(MINC, MAXC, MINC, 1, 1)));
    send_request(bin_query(0));
    send_request(bin_query(4));
    send_request(bin_query(10));
    send_request(bin_query(199));
    send_request(bin_query(LAST_BIN));
    send_request(bin_query(LAST_BIN + 1));
    send_request(bin_query(255));
  endtask

  task automatic test_register_extremes();
    quiesce();
    write_reg(REG_CELL_X, 18'd1);
    write_reg(REG_CELL_Y, 18'h3FFFF);
    write_reg(REG_BIN_WIDTH, 18'd1023);
    settings_used++;
    send_request(pair_of(place(100, MAXC, 0, 1, 1), place(0, MINC, 0, 1, 1)));
    send_request(bin_query(0));
    quiesce();
    write_reg(REG_CELL_X, 18'd20000);
    write_reg(REG_CELL_Y, 18'd20000);
    // zero bin width counts as width one
    write_reg(REG_BIN_WIDTH, 18'd0);
    settings_used++;
    send_request(pair_of(place(150, 0, 0, 0, 1), place(0, 0, 0, 1, 1)));
    send_request(pair_of(place(0, 200, 0, 1, 1), place(0, 0, 0, 1, 1)));
    send_request(pair_of(place(0, 0, 201, 0, 1), place(0, 0, 0, 0, 1)));
    quiesce();
    // write to an index with no register behind it
    write_reg(REG_UNUSED, 18'd7);
    send_request(pair_of(place(0, 150, 0, 0, 1), place(0, 0, 0, 1, 1)));
    send_request(bin_query(150));
    send_request(bin_query(LAST_BIN));
  endtask

  task automatic random_mix(int n);
    hist_req_t r;
    atom_t a, b;
    int h, pick;
    for (int i = 0; i < n; i++) begin
      h = ((bin_w_now == 0) ? 1 : int'(bin_w_now)) * LAST_BIN / 2;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        r = bin_query(($urandom_range(0, 99) < 85) ? $urandom_range(0, LAST_BIN)
                                                    : $urandom_range(0, 255));
      end else if (pick < 30) begin
        r = pair_of(any_atom(), any_atom());
      end else begin
        a = any_atom();
        a.bulk = 1'b1;
        b = place(a.x + spread(h), a.y + spread(h), a.z + spread(h),
                  1'($urandom_range(0, 1)), 1'b1);
        if (pick < 50) begin
          // atoms on opposite faces of the cell
          a.x = CW'(int'(cell_x_now / 2) - int'($urandom_range(0, h)));
          b.x = CW'(int'(a.x) - int'(cell_x_now) + spread(h));
          if ($urandom_range(0, 1)) begin
            a.y = CW'(int'($urandom_range(0, h)) - int'(cell_y_now / 2));
            b.y = CW'(int'(a.y) + int'(cell_y_now) + spread(h));
          end
        end
        if (pick < 36) begin
          case ($urandom_range(0, 2))
            0: a.bulk = 1'b0;
            1: b.bulk = 1'b0;
            default: begin
              a.bulk = 1'b0;
              b.bulk = 1'b0;
            end
          endcase
        end
        r = pair_of(a, b);
      end
      send_request(r);
    end
  endtask

  task automatic test_random_phase(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                                   logic [BINW_W-1:0] bw, int n, bit no_gaps);
    quiesce();
    write_reg(REG_CELL_X, cx);
    write_reg(REG_CELL_Y, cy);
    // upper data bits beyond the bin width register are dropped
    write_reg(REG_BIN_WIDTH, {8'($urandom), bw});
    settings_used++;
    steady = no_gaps;
    random_mix(n);
    steady = 1'b0;
  endtask

  task automatic test_bin_sweep();
    for (int bin = 0; bin <= 255; bin++) send_request(bin_query(bin));
  endtask

  initial begin
    for (int i = 0; i <= LAST_BIN; i++)
      for (int k = 0; k < 3; k++) bin_tally[i][k] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_pairs();
    test_register_extremes();
    test_random_phase(18'd20000, 18'd20000, 10'd50, 140, 1'b0);
    test_bin_sweep();
    test_random_phase(18'd1, 18'h3FFFF, 10'd1, 135, 1'b0);
    test_random_phase(18'h3FFFF, 18'h3FFFF, 10'd1023, 135, 1'b1);
    test_random_phase(18'($urandom), 18'($urandom), 10'd0, 135, 1'b0);
    test_random_phase(18'($urandom_range(1000, 262143)), 18'($urandom_range(1000, 262143)),
                      10'($urandom_range(1, 1023)), 135, 1'b0);
    test_random_phase(18'($urandom_range(1, 262143)), 18'($urandom_range(1, 262143)),
                      10'($urandom_range(1, 60)), 140, 1'b0);
    test_bin_sweep();

    quiesce();
    $display("%0d requests over %0d register settings, %0d bin reports checked",
             requests_sent, settings_used, reports_checked);
    $display("covered wrap boundaries, unwrapped z, bulk filtering, bin range and width zero");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
